// File: rtl/ferc_pkg.sv
package ferc_pkg;

	localparam int DEPTH_DEF        = 16;
	localparam int TAG_BITS_DEF     = 48;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int VERSION_BITS_DEF = 32;

	localparam int              MAX_ENTRIES_W   = 5;
	localparam logic [4:0]      MAX_ENTRIES_RST = 5'd16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_QUERY  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE
	} state_t;

endpackage

// File: rtl/ferc_ram.sv
module ferc_ram import ferc_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/fifo_evicting_resource_cache_core.sv
// channel   ports                                         handshake
// -------   -------------------------------------------   ---------------------------
// item in   op key_tag data_version entry_payload         start high, busy low
//           entry_uploaded_version
// result    hit out_payload out_uploaded_version          done high for one cycle
//           needs_upload evicted
// config    cfg_wr_data (max_entries)                     cfg_wr_en high
//
// find, query and insert scan the occupied slots through the key memory, one slot
// read per cycle, stopping at the first match, so a miss takes longer than a hit;
// clear skips the scan and goes straight to resolve. the next item is taken in the
// cycle that done is shown.
// reset empties the table and sets max_entries to 16; memory contents are kept.
// done cannot be held off by the receiver.
module fifo_evicting_resource_cache_core import ferc_pkg::*; #(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int TAG_BITS     = TAG_BITS_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	parameter int VERSION_BITS = VERSION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               op,
	input  logic [TAG_BITS-1:0]      key_tag,
	input  logic [VERSION_BITS-1:0]  data_version,
	input  logic [PAYLOAD_BITS-1:0]  entry_payload,
	input  logic [VERSION_BITS-1:0]  entry_uploaded_version,
	input  logic                     cfg_wr_en,
	input  logic [MAX_ENTRIES_W-1:0] cfg_wr_data,
	output logic                     done,
	output logic                     hit,
	output logic [PAYLOAD_BITS-1:0]  out_payload,
	output logic [VERSION_BITS-1:0]  out_uploaded_version,
	output logic                     needs_upload,
	output logic                     evicted
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int EW = (CW > MAX_ENTRIES_W) ? CW : MAX_ENTRIES_W;
	localparam int KW = TAG_BITS + VERSION_BITS;
	localparam int DW = PAYLOAD_BITS + VERSION_BITS;

	state_t state_q, state_d;

	op_t                     op_q;
	logic [TAG_BITS-1:0]     tag_q;
	logic [VERSION_BITS-1:0] ver_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [VERSION_BITS-1:0] upl_q;

	logic [AW-1:0]            oldest_q;
	logic [CW-1:0]            occ_q;
	logic [MAX_ENTRIES_W-1:0] max_entries_q;

	logic [CW-1:0] scan_off_q;
	logic [AW-1:0] scan_slot_q;
	logic          cmp_vld_s1;
	logic [AW-1:0] cmp_slot_s1;

	logic                    hit_q;
	logic [AW-1:0]           hit_slot_q;
	logic [PAYLOAD_BITS-1:0] hit_pay_q;
	logic [VERSION_BITS-1:0] hit_upl_q;

	logic                    done_q, hit_out_q, needs_q, evicted_q;
	logic [PAYLOAD_BITS-1:0] out_pay_q;
	logic [VERSION_BITS-1:0] out_upl_q;

	logic [KW-1:0] key_rd_s1;
	logic [DW-1:0] data_rd_s1;

	logic          accept, key_match, found, issue;
	logic          wr_key, wr_data;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] cap;
	logic [EW-1:0] me_ext;
	logic          full, do_evict;
	logic [SW-1:0] app_sum;
	logic [AW-1:0] app_slot;
	logic [AW-1:0] oldest_inc, scan_slot_inc;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign key_match = (key_rd_s1 == {tag_q, ver_q});

	// capacity clamped to 1..DEPTH
	assign me_ext = EW'(max_entries_q);
	always_comb begin
		if (max_entries_q == '0) begin
			cap = CW'(1);
		end else if (me_ext > EW'(DEPTH)) begin
			cap = CW'(DEPTH);
		end else begin
			cap = CW'(me_ext);
		end
	end

	assign full     = (occ_q >= cap);
	assign do_evict = !hit_q && full && (occ_q != '0);

	// new entry goes at oldest + occupancy, same slot with or without eviction
	always_comb begin
		app_sum = SW'(oldest_q) + SW'(occ_q);
		if (app_sum >= SW'(DEPTH)) begin
			app_sum = app_sum - SW'(DEPTH);
		end
	end
	assign app_slot = AW'(app_sum);

	assign oldest_inc    = (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + AW'(1);
	assign scan_slot_inc = (scan_slot_q == AW'(DEPTH - 1)) ? '0 : scan_slot_q + AW'(1);

	always_comb begin
		state_d = state_q;
		found   = 1'b0;
		issue   = 1'b0;
		wr_key  = 1'b0;
		wr_data = 1'b0;
		wr_addr = hit_q ? hit_slot_q : app_slot;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (op_t'(op) == OP_CLEAR) ? ST_RESOLVE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cmp_vld_s1 && key_match) begin
					found   = 1'b1;
					state_d = ST_RESOLVE;
				end else begin
					issue = (scan_off_q != occ_q);
					if (!issue && !cmp_vld_s1) begin
						state_d = ST_RESOLVE;
					end
				end
			end
			ST_RESOLVE: begin
				state_d = ST_IDLE;
				if (op_q == OP_INSERT) begin
					wr_data = 1'b1;
					wr_key  = !hit_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	ferc_ram #(.DEPTH(DEPTH), .WIDTH(KW)) u_key_ram (
		.clk     (clk),
		.wr_en   (wr_key),
		.wr_addr (wr_addr),
		.wr_data ({tag_q, ver_q}),
		.rd_en   (issue),
		.rd_addr (scan_slot_q),
		.rd_data (key_rd_s1)
	);

	ferc_ram #(.DEPTH(DEPTH), .WIDTH(DW)) u_data_ram (
		.clk     (clk),
		.wr_en   (wr_data),
		.wr_addr (wr_addr),
		.wr_data ({pay_q, upl_q}),
		.rd_en   (issue),
		.rd_addr (scan_slot_q),
		.rd_data (data_rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			oldest_q      <= '0;
			occ_q         <= '0;
			max_entries_q <= MAX_ENTRIES_RST;
			cmp_vld_s1    <= 1'b0;
			hit_q         <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue;
			done_q     <= (state_q == ST_RESOLVE);
			if (cfg_wr_en) begin
				max_entries_q <= cfg_wr_data;
			end
			if (accept) begin
				hit_q <= 1'b0;
			end else if (found) begin
				hit_q <= 1'b1;
			end
			if (state_q == ST_RESOLVE) begin
				if (op_q == OP_CLEAR) begin
					oldest_q <= '0;
					occ_q    <= '0;
				end else if (op_q == OP_INSERT && !hit_q) begin
					if (do_evict) begin
						oldest_q <= oldest_inc;
					end else begin
						occ_q <= occ_q + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op_t'(op);
			tag_q       <= key_tag;
			ver_q       <= data_version;
			pay_q       <= entry_payload;
			upl_q       <= entry_uploaded_version;
			scan_off_q  <= '0;
			scan_slot_q <= oldest_q;
		end else if (issue) begin
			scan_off_q  <= scan_off_q + CW'(1);
			scan_slot_q <= scan_slot_inc;
		end
		if (issue) begin
			cmp_slot_s1 <= scan_slot_q;
		end
		if (found) begin
			hit_slot_q <= cmp_slot_s1;
			hit_pay_q  <= data_rd_s1[DW-1:VERSION_BITS];
			hit_upl_q  <= data_rd_s1[VERSION_BITS-1:0];
		end
		if (state_q == ST_RESOLVE) begin
			unique case (op_q)
				OP_CLEAR: begin
					hit_out_q <= 1'b0;
					out_pay_q <= '0;
					out_upl_q <= '0;
					needs_q   <= 1'b0;
					evicted_q <= 1'b0;
				end
				OP_INSERT: begin
					hit_out_q <= hit_q;
					out_pay_q <= pay_q;
					out_upl_q <= upl_q;
					needs_q   <= (upl_q != ver_q);
					evicted_q <= do_evict;
				end
				OP_FIND, OP_QUERY: begin
					hit_out_q <= hit_q;
					out_pay_q <= hit_q ? hit_pay_q : '0;
					out_upl_q <= hit_q ? hit_upl_q : '0;
					needs_q   <= hit_q ? (hit_upl_q != ver_q) : 1'b1;
					evicted_q <= 1'b0;
				end
				default: begin
					hit_out_q <= 1'b0;
					out_pay_q <= '0;
					out_upl_q <= '0;
					needs_q   <= 1'b0;
					evicted_q <= 1'b0;
				end
			endcase
		end
	end

	assign done                 = done_q;
	assign hit                  = hit_out_q;
	assign out_payload          = out_pay_q;
	assign out_uploaded_version = out_upl_q;
	assign needs_upload         = needs_q;
	assign evicted              = evicted_q;

endmodule
